// ===== hw/rtl/ltx_pkg.sv =====
package ltx_pkg;

  localparam logic [2:0] CS_ASCII   = 3'd0;
  localparam logic [2:0] CS_LATIN1  = 3'd1;
  localparam logic [2:0] CS_UTF8    = 3'd2;
  localparam logic [2:0] CS_UTF8MB4 = 3'd3;

  localparam logic [1:0] CFG_SOURCE = 2'd0;
  localparam logic [1:0] CFG_TARGET = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOIMPL  = 2'd2;

  localparam logic [7:0] QMARK = 8'h3F;

  typedef enum logic [2:0] {
    MODE_PASS,
    MODE_L2U,
    MODE_U2L,
    MODE_U2A,
    MODE_NONE
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cont_left;
    logic [2:0] seq_len;
    logic [4:0] lead_payload;
    logic       dropping;
  } dec_state_t;

  function automatic mode_t select_mode(input logic [2:0] s, input logic [2:0] t);
    logic t_utf8;
    mode_t m;
    t_utf8 = (t == CS_UTF8) || (t == CS_UTF8MB4);
    m = MODE_NONE;
    if (s == t) begin
      m = MODE_PASS;
    end else if (s == CS_ASCII && t_utf8) begin
      m = MODE_PASS;
    end else if (s == CS_LATIN1 && t_utf8) begin
      m = MODE_L2U;
    end else if (s == CS_UTF8 || s == CS_UTF8MB4) begin
      if (t == CS_LATIN1) begin
        m = MODE_U2L;
      end else if (t == CS_ASCII) begin
        m = MODE_U2A;
      end else if (t_utf8) begin
        m = MODE_PASS;
      end
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/latin1_utf8_ascii_transcoder.sv =====
// Charset transcoder for byte strings (ASCII, Latin1, UTF-8). Bytes enter on
// the s_axis port with tlast on the final byte of each string and leave on
// m_axis, one result word per cycle when m_axis_tready is high, tlast on the
// last result of a string and tuser carrying has_byte and status (status-only
// words have tdata zero). The input side takes one byte per cycle while the
// queue has room; a Latin1 byte of 0x80 or more converted to UTF-8 yields two
// words and is held until both fit, as m_axis moves one word per cycle. Bytes
// pass through the input register and the two-entry result queue. Source and
// target charsets are set over the cfg port (index 0 source, 1 target) while
// the stream is idle; a write also resets the UTF-8 decode state.
module latin1_utf8_ascii_transcoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] has_byte, [2:1] status
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic [2:0]          src_cs;
  logic [2:0]          tgt_cs;
  ltx_pkg::mode_t      mode;
  ltx_pkg::dec_state_t st;
  ltx_pkg::dec_state_t st_next;
  logic                in_vld;
  logic [7:0]          in_byte;
  logic                in_last;
  logic [1:0]          nres;
  ltx_pkg::res_t       r0;
  ltx_pkg::res_t       r1;
  ltx_pkg::res_t       head;
  logic [1:0]          cnt;
  logic [2:0]          space;
  logic                pop;
  logic                commit;
  logic                cfg_wr;

  assign mode   = ltx_pkg::select_mode(src_cs, tgt_cs);
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign space  = 3'd2 - {1'b0, cnt} + {2'b00, pop};
  assign commit = in_vld && ({1'b0, nres} <= space);
  assign s_axis_tready = !in_vld || commit;
  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready &&
                  (cfg_index == ltx_pkg::CFG_SOURCE || cfg_index == ltx_pkg::CFG_TARGET);

  ltx_decode u_decode (
    .mode    (mode),
    .st      (st),
    .in_byte (in_byte),
    .in_last (in_last),
    .nres    (nres),
    .r0      (r0),
    .r1      (r1),
    .st_next (st_next)
  );

  ltx_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .npush (commit ? nres : 2'd0),
    .r0    (r0),
    .r1    (r1),
    .pop   (pop),
    .cnt   (cnt),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cs <= ltx_pkg::CS_UTF8;
      tgt_cs <= ltx_pkg::CS_UTF8;
      st     <= '0;
      in_vld <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld <= 1'b1;
      end else if (commit) begin
        in_vld <= 1'b0;
      end
      if (cfg_wr) begin
        st <= '0;
        if (cfg_index == ltx_pkg::CFG_SOURCE) begin
          src_cs <= cfg_data;
        end else begin
          tgt_cs <= cfg_data;
        end
      end else if (commit) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = head.out_byte;
  assign m_axis_tuser  = {head.status, head.has_byte};
  assign m_axis_tlast  = head.is_last;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue overflow");
  a_drop_mode: assert property (@(posedge clk) disable iff (rst)
    st.dropping |-> (mode == ltx_pkg::MODE_U2L || mode == ltx_pkg::MODE_U2A))
    else $error("drop state outside utf8 decode");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_vld |-> s_axis_tready)
    else $error("input stalled while empty");
  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    (commit && !(s_axis_tvalid && s_axis_tready)) |=> !in_vld)
    else $error("input word not released after commit");
`endif

endmodule

// ===== hw/rtl/ltx_decode.sv =====
module ltx_decode (
  input  ltx_pkg::mode_t      mode,
  input  ltx_pkg::dec_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic [1:0]          nres,
  output ltx_pkg::res_t       r0,
  output ltx_pkg::res_t       r1,
  output ltx_pkg::dec_state_t st_next
);

  localparam ltx_pkg::dec_state_t CLEAR = '0;

  ltx_pkg::res_t copy_res;
  ltx_pkg::res_t inval_res;
  logic [10:0]   cp;
  logic [7:0]    val;

  always_comb begin
    copy_res  = '{out_byte: in_byte, has_byte: 1'b1, status: ltx_pkg::ST_OK,
                  is_last: in_last};
    inval_res = '{out_byte: 8'h00, has_byte: 1'b0, status: ltx_pkg::ST_INVALID,
                  is_last: 1'b1};
    cp  = {st.lead_payload, in_byte[5:0]};
    val = ltx_pkg::QMARK;
    if (mode == ltx_pkg::MODE_U2L && st.seq_len == 3'd2 && cp[10:8] == 3'b000) begin
      val = cp[7:0];
    end

    nres    = 2'd0;
    r0      = copy_res;
    r1      = copy_res;
    st_next = st;

    case (mode)
      ltx_pkg::MODE_PASS: begin
        nres = 2'd1;
      end
      ltx_pkg::MODE_L2U: begin
        if (!in_byte[7]) begin
          nres = 2'd1;
        end else begin
          nres = 2'd2;
          r0 = '{out_byte: {6'b110000, in_byte[7:6]}, has_byte: 1'b1,
                 status: ltx_pkg::ST_OK, is_last: 1'b0};
          r1.out_byte = {2'b10, in_byte[5:0]};
        end
      end
      ltx_pkg::MODE_U2L, ltx_pkg::MODE_U2A: begin
        if (st.dropping) begin
          if (in_last) begin
            st_next = CLEAR;
          end
        end else if (st.cont_left != 2'd0) begin
          if (st.cont_left == 2'd1) begin
            st_next = CLEAR;
            nres = 2'd1;
            r0.out_byte = val;
          end else begin
            st_next.cont_left = st.cont_left - 2'd1;
            if (in_last) begin
              st_next = CLEAR;
              nres = 2'd1;
              r0 = inval_res;
            end
          end
        end else if (!in_byte[7]) begin
          nres = 2'd1;
        end else if (in_last || in_byte[6] == 1'b0 ||
                     in_byte[7:3] == 5'b11111) begin
          // bad lead byte, or the string ends on a lead byte
          st_next = CLEAR;
          st_next.dropping = !in_last;
          nres = 2'd1;
          r0 = inval_res;
        end else begin
          if (!in_byte[5]) begin
            st_next.seq_len = 3'd2;
            st_next.cont_left = 2'd1;
          end else if (!in_byte[4]) begin
            st_next.seq_len = 3'd3;
            st_next.cont_left = 2'd2;
          end else begin
            st_next.seq_len = 3'd4;
            st_next.cont_left = 2'd3;
          end
          st_next.lead_payload = in_byte[4:0];
        end
      end
      default: begin
        if (in_last) begin
          nres = 2'd1;
          r0 = '{out_byte: 8'h00, has_byte: 1'b0, status: ltx_pkg::ST_NOIMPL,
                 is_last: 1'b1};
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/ltx_outq.sv =====
module ltx_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    npush,
  input  ltx_pkg::res_t r0,
  input  ltx_pkg::res_t r1,
  input  logic          pop,
  output logic [1:0]    cnt,
  output ltx_pkg::res_t head
);

  ltx_pkg::res_t q [2];
  ltx_pkg::res_t q_next [2];
  logic [1:0]    cnt_next;
  logic [1:0]    cnt_p;

  always_comb begin
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[1];
      cnt_p = cnt - 2'd1;
    end else begin
      q_next[0] = q[0];
      q_next[1] = q[1];
      cnt_p = cnt;
    end
    if (npush != 2'd0) begin
      if (cnt_p == 2'd0) begin
        q_next[0] = r0;
        q_next[1] = r1;
      end else begin
        q_next[1] = r0;
      end
    end
    cnt_next = cnt_p + npush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  assign head = q[0];

endmodule
